/* rtl/core/stlb_pkg.sv */
package stlb_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 11;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic init;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
  } dp_status_t;

endpackage

/* rtl/core/stlb_ctrl.sv */
module stlb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  command,
  input  stlb_pkg::dp_status_t  status,
  output stlb_pkg::dp_cmd_t     cmd,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t state;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    cmd.append = accept && (command == stlb_pkg::CMD_APPEND);
    cmd.init   = accept && (command == stlb_pkg::CMD_QUERY);
    cmd.step   = (state == ST_SEARCH) && status.active;
    cmd.finish = (state == ST_SEARCH) && !status.active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd.init) begin
            state <= ST_SEARCH;
            busy  <= 1'b1;
          end
        end
        ST_SEARCH: begin
          // interval empty: hand the answer out and drop back to idle
          if (!status.active) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/stlb_dp.sv */
module stlb_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stlb_pkg::dp_cmd_t                    cmd,
  input  logic                                 start_new,
  input  logic signed [stlb_pkg::VALUE_W-1:0]  value,
  output stlb_pkg::dp_status_t                 status,
  output logic [stlb_pkg::POS_W-1:0]           position,
  output logic                                 past_end
);

  logic signed [stlb_pkg::VALUE_W-1:0] mem [stlb_pkg::TABLE_DEPTH];

  logic [stlb_pkg::COUNT_W-1:0]        count;
  logic [stlb_pkg::COUNT_W-1:0]        low;
  logic [stlb_pkg::COUNT_W-1:0]        low_next;
  logic [stlb_pkg::COUNT_W-1:0]        hp1;
  logic [stlb_pkg::COUNT_W-1:0]        hp1_next;
  logic [stlb_pkg::COUNT_W-1:0]        found;
  logic [stlb_pkg::COUNT_W-1:0]        found_next;
  logic [stlb_pkg::COUNT_W-1:0]        span;
  logic [stlb_pkg::COUNT_W-1:0]        mid_full;
  logic [stlb_pkg::ADDR_W-1:0]         mid;
  logic signed [stlb_pkg::VALUE_W-1:0] target;
  logic signed [stlb_pkg::VALUE_W-1:0] rdata;
  logic                                hit;
  logic                                wr_en;
  logic [stlb_pkg::ADDR_W-1:0]         wr_addr;

  // append: restart at entry 0, or add at the end while room remains
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[stlb_pkg::ADDR_W-1:0];
    if (cmd.append) begin
      if (start_new) begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (count < stlb_pkg::COUNT_W'(stlb_pkg::TABLE_DEPTH)) begin
        wr_en = 1'b1;
      end
    end
  end

  assign hit = (rdata >= target);

  // search window is [low, hp1); rdata holds the entry at the current mid
  always_comb begin
    low_next   = low;
    hp1_next   = hp1;
    found_next = found;
    if (cmd.init) begin
      low_next   = '0;
      hp1_next   = count;
      found_next = count;
    end else if (cmd.step) begin
      if (hit) begin
        found_next = stlb_pkg::COUNT_W'(mid);
        hp1_next   = stlb_pkg::COUNT_W'(mid);
      end else begin
        low_next = stlb_pkg::COUNT_W'(mid) + 1'b1;
      end
    end
  end

  assign span     = hp1_next - low_next - 1'b1;
  assign mid_full = low_next + (span >> 1);

  assign status.active = (low < hp1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    rdata <= mem[mid_full[stlb_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= start_new ? stlb_pkg::COUNT_W'(1) : count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    low   <= low_next;
    hp1   <= hp1_next;
    found <= found_next;
    mid   <= mid_full[stlb_pkg::ADDR_W-1:0];
    if (cmd.init) begin
      target <= value;
    end
    if (cmd.finish) begin
      position <= stlb_pkg::POS_W'(found);
      past_end <= (found == count);
    end
  end

endmodule

/* rtl/core/sorted_table_lower_bound.sv */
// Append beat: taken while busy is low, busy stays low, no result strobe.
// Query beat: one probe a cycle, at most ceil(log2(n+1)) probes for n stored
// entries (at most 11 for a full 1024-entry table), set by the registered read
// port of the table memory; done strobes with the result once the window empties.
// No beat is taken while busy is high; appends go in one per cycle otherwise.
// Reset (rst, synchronous) empties the table; the receiver cannot stall done.
module sorted_table_lower_bound (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic                                 start_new,
  input  logic signed [stlb_pkg::VALUE_W-1:0]  value,
  output logic                                 done,
  output logic [stlb_pkg::POS_W-1:0]           position,
  output logic                                 past_end
);

  // command and status between sequencer and datapath
  stlb_pkg::dp_cmd_t    cmd;
  stlb_pkg::dp_status_t status;

  // sequencer: accept beats, step the search, strobe the answer
  stlb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  // datapath: table memory, entry count, search window and result registers
  stlb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .start_new (start_new),
    .value     (value),
    .status    (status),
    .position  (position),
    .past_end  (past_end)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import stlb_pkg::*;

  localparam int ITEM_TARGET = 1650;    // rough size of the whole stimulus
  localparam int QUIET_TAIL  = 120;     // last beats go in back to back
  localparam int DRAIN_WAIT  = 20;      // settle time after the queues run dry
  localparam int CYCLE_LIMIT = 300000;  // watchdog limit, far above a clean run

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                        command;
    logic                        start_new;
    logic signed [VALUE_W-1:0]   value;
  } beat_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             past_end;
  } bound_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       command = CMD_APPEND;
  logic                       start_new = 1'b0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       done;
  logic [POS_W-1:0]           position;
  logic                       past_end;

  sorted_table_lower_bound DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .start_new (start_new),
    .value     (value),
    .done      (done),
    .position  (position),
    .past_end  (past_end)
  );

  always #2 clk = ~clk;

  // Beats waiting to go in, and lower bounds waiting to come out.
  beat_t  pending_beats[$];
  bound_t expected_bounds[$];

  // Mirror of the table, updated as each beat is taken.
  logic signed [VALUE_W-1:0] stored_values [TABLE_DEPTH];
  int                        stored_count = 0;

  // What the stimulus planner believes the table holds, for picking targets.
  logic signed [VALUE_W-1:0] planned_values[$];

  int beats_planned   = 0;
  int beats_taken     = 0;
  int queries_checked = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int idle_left       = 0;
  bit full_table_hit  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Binary search exactly as the block runs it: keep the last mid that held a
  // value at or above the target, even if the table is out of order.
  function automatic logic [POS_W-1:0] lower_bound(input logic signed [VALUE_W-1:0] target);
    int          lo;
    int          hi;
    int          mid;
    int unsigned found;
    lo    = 0;
    hi    = stored_count - 1;
    found = stored_count;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored_values[mid] >= target) begin
        found = mid;
        hi    = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return found[POS_W-1:0];
  endfunction

  // Apply one taken beat to the mirror; a query queues its expected bound.
  task automatic commit_beat(input beat_t b);
    bound_t r;
    if (b.command == CMD_APPEND) begin
      if (b.start_new) stored_count = 0;
      if (stored_count < TABLE_DEPTH) begin
        stored_values[stored_count] = b.value;
        stored_count++;
      end
    end else begin
      r.position = lower_bound(b.value);
      r.past_end = (r.position == stored_count);
      if (stored_count == TABLE_DEPTH) full_table_hit = 1'b1;
      expected_bounds.push_back(r);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] clamp32(input longint v);
    if (v > longint'(VALUE_MAX)) return VALUE_MAX;
    if (v < longint'(VALUE_MIN)) return VALUE_MIN;
    return v[VALUE_W-1:0];
  endfunction

  task automatic push_append(input logic sn, input logic signed [VALUE_W-1:0] v);
    beat_t b;
    if (sn) planned_values.delete();
    if (planned_values.size() < TABLE_DEPTH) planned_values.push_back(v);
    b.command   = CMD_APPEND;
    b.start_new = sn;
    b.value     = v;
    pending_beats.push_back(b);
    beats_planned++;
  endtask

  task automatic push_query(input logic sn, input logic signed [VALUE_W-1:0] v);
    beat_t b;
    b.command   = CMD_QUERY;
    b.start_new = sn;
    b.value     = v;
    pending_beats.push_back(b);
    beats_planned++;
  endtask

  // Aim most targets at or next to stored values so the search hits ties,
  // and the rest at the extremes or anywhere.
  function automatic logic signed [VALUE_W-1:0] pick_target();
    int                        k;
    logic signed [VALUE_W-1:0] v;
    k = $urandom_range(0, 9);
    if (planned_values.size() == 0 || k >= 8) return $urandom;
    v = planned_values[$urandom_range(0, planned_values.size() - 1)];
    case (k)
      4: return clamp32(longint'(v) + 1);
      5: return clamp32(longint'(v) - 1);
      6: return VALUE_MIN;
      7: return VALUE_MAX;
      default: return v;
    endcase
  endfunction

  // Fresh ascending table of n entries, then queries; sometimes extend it.
  task automatic plan_sorted_run(input int n, input int max_step);
    longint cur;
    int     nq;
    cur = longint'($signed($urandom));
    for (int i = 0; i < n; i++) begin
      if (i > 0) cur += $urandom_range(0, max_step);
      push_append(i == 0, clamp32(cur));
    end
    nq = $urandom_range(1, 10);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        cur += $urandom_range(0, max_step);
        push_append(1'b0, clamp32(cur));
      end
      push_query(1'($urandom_range(0, 1)), pick_target());
    end
  endtask

  // Driver: hold a beat while busy, advance on acceptance, idle in bursts.
  always @(posedge clk) begin : drive_beats
    bit choppy;
    if (rst) begin
      start     <= 1'b0;
      command   <= CMD_APPEND;
      start_new <= 1'b0;
      value     <= '0;
      idle_left  = 0;
    end else begin
      if (start && !busy) begin
        commit_beat(pending_beats.pop_front());
        beats_taken++;
        // Two stretches out of three are choppy, the third runs clean.
        choppy = ((beats_taken / 150) % 3) != 2;
        if (choppy && pending_beats.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
          idle_left = $urandom_range(1, 4);
      end
      if (start && busy) begin
        // hold the beat until the block takes it
      end else if (idle_left > 0 || pending_beats.size() == 0) begin
        start <= 1'b0;
        if (idle_left > 0) idle_left--;
      end else begin
        start     <= 1'b1;
        command   <= pending_beats[0].command;
        start_new <= pending_beats[0].start_new;
        value     <= pending_beats[0].value;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding bound.
  always @(posedge clk) begin : check_bounds
    bound_t want;
    if (!rst && done) begin
      if (expected_bounds.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding: position %0d past_end %0b",
                                  position, past_end));
      end else begin
        want = expected_bounds.pop_front();
        queries_checked++;
        if (position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", position, want.position));
        if (past_end !== want.past_end)
          report_mismatch($sformatf("past_end %0b, want %0b", past_end, want.past_end));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d beats still pending",
               cycle_count, pending_beats.size());
      $display("sorted_table_lower_bound test failed");
      $finish;
    end
  end

  initial begin
    int     kind;
    int     n;
    longint cur;

    // Directed: empty table, start flag on a query is ignored.
    push_query(1'b0, 32'sd0);
    push_query(1'b1, VALUE_MIN);
    // Extremes and a duplicate in a sorted table.
    push_append(1'b1, VALUE_MIN);
    push_append(1'b0, -32'sd5);
    push_append(1'b0, 32'sd0);
    push_append(1'b0, 32'sd0);
    push_append(1'b0, 32'sd7);
    push_append(1'b0, VALUE_MAX);
    push_query(1'b0, VALUE_MIN);
    push_query(1'b0, VALUE_MIN + 1);
    push_query(1'b0, -32'sd5);
    push_query(1'b0, -32'sd4);
    push_query(1'b0, 32'sd0);
    push_query(1'b0, 32'sd1);
    push_query(1'b0, 32'sd8);
    push_query(1'b0, VALUE_MAX);
    push_query(1'b1, 32'sd7);
    // Out-of-order table: the search answer stands as it falls.
    push_append(1'b1, 32'sd10);
    push_append(1'b0, 32'sd3);
    push_append(1'b0, 32'sd20);
    push_append(1'b0, -32'sd1);
    push_query(1'b0, 32'sd3);
    push_query(1'b0, 32'sd15);
    push_query(1'b0, -32'sd100);
    push_query(1'b0, 32'sd25);

    // Fill the table to the brim, staying below the top so past_end can hit
    // position 1024; then overflow, and restart on a full table.
    cur = longint'(VALUE_MIN) + $urandom_range(0, 1000);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i > 0) cur += $urandom_range(0, 4190000);
      push_append(i == 0, clamp32(cur));
    end
    push_query(1'b0, VALUE_MAX);
    push_query(1'b0, VALUE_MIN);
    for (int i = 0; i < 30; i++) push_query(1'($urandom_range(0, 1)), pick_target());
    push_append(1'b0, $urandom);
    push_query(1'b0, VALUE_MAX);
    push_query(1'b0, planned_values[TABLE_DEPTH - 1]);
    push_append(1'b1, $urandom);
    push_query(1'b0, VALUE_MAX);
    push_query(1'b0, VALUE_MIN);

    // Random part: mostly well-formed sorted runs, some unsorted, some noise.
    while (beats_planned < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
        case ($urandom_range(0, 3))
          0: plan_sorted_run(n, 3);
          1: plan_sorted_run(n, 1000);
          2: plan_sorted_run(n, 1 << 24);
          default: plan_sorted_run(n, 32'h7fff_ffff);
        endcase
      end else if (kind < 9) begin
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) push_append(i == 0, $urandom);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_query(1'($urandom_range(0, 1)), pick_target());
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) == 0) push_append(1'($urandom_range(0, 1)), $urandom);
          else push_query(1'($urandom_range(0, 1)), $urandom);
        end
      end
    end

    // Release reset once, then let the driver run the queue dry.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() != 0 || expected_bounds.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d beats and checked %0d lower-bound results in %0d cycles.",
             beats_taken, queries_checked, cycle_count);
    $display("Covered empty, sorted, unsorted and %s tables, with overflow appends.",
             full_table_hit ? "completely full" : "partly full");
    if (mismatches == 0) begin
      $display("sorted_table_lower_bound test passed");
    end else begin
      $display("%0d mismatches seen", mismatches);
      $display("sorted_table_lower_bound test failed");
    end
    $finish;
  end

endmodule

/* sorted_table_lower_bound.f */
rtl/core/stlb_pkg.sv
rtl/core/stlb_ctrl.sv
rtl/core/stlb_dp.sv
rtl/core/sorted_table_lower_bound.sv
test/testbench.sv
